### design/sbt_pkg.sv
// Shared types and constants for the sorted breakpoint table.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package sbt_pkg;

	// Default sizing of the table
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int ADDR_WIDTH_DEF  = 32;

	// Fixed field widths of the request and response words
	localparam int CMD_W      = 2;
	localparam int ADDRESS_W  = 32;
	localparam int POSITION_W = 6;
	localparam int COUNT_W    = 7;
	localparam int STATUS_W   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_MODIFY = 2'd2,
		CMD_FIND   = 2'd3
	} cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_NOCHANGE = 2'd2,
		ST_FULL     = 2'd3
	} status_e;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DECIDE,
		S_INS_STEP,
		S_INS_WR,
		S_DEL_STEP,
		S_DEL_WR,
		S_FINISH
	} state_e;

	// Read address source relative to the working index
	typedef enum logic [1:0] {
		RD_CUR,
		RD_PREV,
		RD_NEXT
	} rd_sel_e;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [ADDRESS_W-1:0] address;
		logic                 enabled;
	} req_word_t;

	typedef struct packed {
		logic                  present;
		logic [POSITION_W-1:0] position;
		logic [COUNT_W-1:0]    entry_count;
		logic [STATUS_W-1:0]   status;
	} rsp_word_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    cap_in;
		logic    idx_clr;
		logic    idx_inc;
		logic    idx_dec;
		logic    idx_load_cnt;
		logic    idx_load_pos;
		logic    pos_load;
		logic    pos_hit;
		logic    rd_en;
		rd_sel_e rd_sel;
		logic    wr_en;
		logic    wr_key;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    out_load;
		status_e out_status;
	} dp_ctrl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		cmd_e cmd;
		logic en;
		logic found;
		logic idx_at_cnt;
		logic rd_lt;
		logic rd_eq;
		logic idx_eq_pos;
		logic idx_last;
		logic full;
	} dp_stat_t;

endpackage

### design/sorted_breakpoint_table_top.sv
// One word at a time: a new word is accepted only after the last one has finished;
// the entries are found by a linear scan and moved by a linear shift through the memory.
// A finished response waits in its output register while the next word is accepted.
// Reset (arst_n low) empties the table and drops the response valid at once.
// Depends on sbt_pkg, sbt_controller and sbt_datapath.
`timescale 1ns / 1ps

module sorted_breakpoint_table_top #(
	parameter int TABLE_DEPTH = sbt_pkg::TABLE_DEPTH_DEF,
	parameter int ADDR_WIDTH  = sbt_pkg::ADDR_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  sbt_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output sbt_pkg::rsp_word_t rsp
);
	import sbt_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	// Sequence the search and the shifts
	sbt_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// Hold the table and build the response
	sbt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ADDR_WIDTH  (ADDR_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctrl   (ctrl),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

### design/sbt_datapath.sv
// Datapath of the sorted breakpoint table: entry memory, working index,
// entry count, comparator and response register. Depends on sbt_pkg.
`timescale 1ns / 1ps

module sbt_datapath #(
	parameter int TABLE_DEPTH = sbt_pkg::TABLE_DEPTH_DEF,
	parameter int ADDR_WIDTH  = sbt_pkg::ADDR_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sbt_pkg::req_word_t req,
	input  sbt_pkg::dp_ctrl_t  ctrl,
	output sbt_pkg::dp_stat_t  stat,
	output sbt_pkg::rsp_word_t rsp
);
	import sbt_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [ADDR_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [ADDR_WIDTH-1:0] rd_q;
	logic [ADDR_WIDTH-1:0] key_q;
	logic [ADDR_WIDTH-1:0] wr_data;
	cmd_e                  cmd_q;
	logic                  en_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         pos_q;
	logic                  found_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         rd_addr;
	logic                  present;
	rsp_word_t             rsp_q;

	// Pick the read address around the working index
	always_comb begin
		unique case (ctrl.rd_sel)
			RD_CUR:  rd_addr = idx_q;
			RD_PREV: rd_addr = idx_q - CW'(1);
			RD_NEXT: rd_addr = idx_q + CW'(1);
			default: rd_addr = idx_q;
		endcase
	end

	assign wr_data = ctrl.wr_key ? key_q : rd_q;

	// Entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[idx_q[IW-1:0]] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_q <= mem[rd_addr[IW-1:0]];
		end
	end

	// Capture the request word
	always_ff @(posedge clk) begin
		if (ctrl.cap_in) begin
			key_q <= ADDR_WIDTH'(req.address);
			cmd_q <= cmd_e'(req.command);
			en_q  <= req.enabled;
		end
	end

	// Working index and search result
	always_ff @(posedge clk) begin
		if (ctrl.idx_clr) begin
			idx_q <= '0;
		end else if (ctrl.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end else if (ctrl.idx_dec) begin
			idx_q <= idx_q - CW'(1);
		end else if (ctrl.idx_load_cnt) begin
			idx_q <= cnt_q;
		end else if (ctrl.idx_load_pos) begin
			idx_q <= pos_q;
		end
		if (ctrl.pos_load) begin
			pos_q   <= idx_q;
			found_q <= ctrl.pos_hit;
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (ctrl.cnt_dec) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// Status toward the controller
	always_comb begin
		stat.cmd        = cmd_q;
		stat.en         = en_q;
		stat.found      = found_q;
		stat.idx_at_cnt = (idx_q == cnt_q);
		stat.rd_lt      = (rd_q < key_q);
		stat.rd_eq      = (rd_q == key_q);
		stat.idx_eq_pos = (idx_q == pos_q);
		stat.idx_last   = ((idx_q + CW'(1)) == cnt_q);
		stat.full       = (cnt_q == CW'(TABLE_DEPTH));
	end

	// Build the response word after the table update
	always_comb begin
		case (ctrl.out_status) inside
			ST_INSERTED:         present = 1'b1;
			ST_REMOVED, ST_FULL: present = 1'b0;
			default:             present = found_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			rsp_q.present     <= present;
			rsp_q.position    <= present ? POSITION_W'(pos_q) : '0;
			rsp_q.entry_count <= COUNT_W'(cnt_q);
			rsp_q.status      <= ctrl.out_status;
		end
	end

	assign rsp = rsp_q;

endmodule

### design/sbt_controller.sv
// Controller of the sorted breakpoint table: sequences search, shift and
// response handshake. Depends on sbt_pkg.
`timescale 1ns / 1ps

module sbt_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  sbt_pkg::dp_stat_t stat,
	output sbt_pkg::dp_ctrl_t ctrl
);
	import sbt_pkg::*;

	state_e  state_q, state_d;
	status_e status_q, status_d;
	logic    out_valid_q;
	logic    ins_req;
	logic    rem_req;

	// Decide what the command does with the search result
	always_comb begin
		ins_req = stat.en && !stat.found &&
			(stat.cmd == CMD_CREATE || stat.cmd == CMD_MODIFY);
		rem_req = stat.found &&
			(stat.cmd == CMD_DELETE || (stat.cmd == CMD_MODIFY && !stat.en));
	end

	// State and result status registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_NOCHANGE;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d         = state_q;
		status_d        = status_q;
		ctrl            = '0;
		ctrl.rd_sel     = RD_CUR;
		ctrl.out_status = status_q;
		req_stall       = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctrl.cap_in  = 1'b1;
					ctrl.idx_clr = 1'b1;
					state_d      = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (stat.idx_at_cnt) begin
					ctrl.pos_load = 1'b1;
					ctrl.pos_hit  = 1'b0;
					state_d       = S_DECIDE;
				end else begin
					ctrl.rd_en = 1'b1;
					state_d    = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (stat.rd_lt) begin
					ctrl.idx_inc = 1'b1;
					state_d      = S_SCAN_RD;
				end else begin
					ctrl.pos_load = 1'b1;
					ctrl.pos_hit  = stat.rd_eq;
					state_d       = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (ins_req && stat.full) begin
					status_d = ST_FULL;
					state_d  = S_FINISH;
				end else if (ins_req) begin
					status_d          = ST_INSERTED;
					ctrl.idx_load_cnt = 1'b1;
					state_d           = S_INS_STEP;
				end else if (rem_req) begin
					status_d          = ST_REMOVED;
					ctrl.idx_load_pos = 1'b1;
					state_d           = S_DEL_STEP;
				end else begin
					status_d = ST_NOCHANGE;
					state_d  = S_FINISH;
				end
			end
			S_INS_STEP: begin
				if (stat.idx_eq_pos) begin
					ctrl.wr_en   = 1'b1;
					ctrl.wr_key  = 1'b1;
					ctrl.cnt_inc = 1'b1;
					state_d      = S_FINISH;
				end else begin
					ctrl.rd_en  = 1'b1;
					ctrl.rd_sel = RD_PREV;
					state_d     = S_INS_WR;
				end
			end
			S_INS_WR: begin
				ctrl.wr_en   = 1'b1;
				ctrl.idx_dec = 1'b1;
				state_d      = S_INS_STEP;
			end
			S_DEL_STEP: begin
				if (stat.idx_last) begin
					ctrl.cnt_dec = 1'b1;
					state_d      = S_FINISH;
				end else begin
					ctrl.rd_en  = 1'b1;
					ctrl.rd_sel = RD_NEXT;
					state_d     = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				ctrl.wr_en   = 1'b1;
				ctrl.idx_inc = 1'b1;
				state_d      = S_DEL_STEP;
			end
			S_FINISH: begin
				if (!out_valid_q || !rsp_stall) begin
					ctrl.out_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Response valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

### design/sbt_checker.sv
// Port-level checks for the sorted breakpoint table, bound to the top level.
// Depends on sbt_pkg and sorted_breakpoint_table_top.
`timescale 1ns / 1ps

module sbt_checker #(
	parameter int TABLE_DEPTH = sbt_pkg::TABLE_DEPTH_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input sbt_pkg::rsp_word_t rsp
);
	import sbt_pkg::*;

	// Hold a stalled response word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response word changed");

	// Busy after accepting a word: one word in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second word accepted before first finished");

	// Absent address reports position zero
	a_absent_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.present |-> rsp.position == '0)
		else $error("position set for absent address");

	// Refused insert only when full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |->
			!rsp.present && rsp.entry_count == COUNT_W'(TABLE_DEPTH))
		else $error("full status with table not full");

	// Insert and remove agree with presence
	a_status_present: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status != ST_INSERTED || rsp.present) &&
			(rsp.status != ST_REMOVED || !rsp.present))
		else $error("status disagrees with presence");

endmodule

bind sorted_breakpoint_table_top sbt_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_sbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### tb/sorted_breakpoint_table_top_tb.sv
// Self-checking bench for the sorted breakpoint table: a short table of directed words, then
// random create/delete/modify/find traffic checked against a shadow sorted set.
// Depends on sbt_pkg and sorted_breakpoint_table_top.
`timescale 1ns / 1ps

module sorted_breakpoint_table_top_tb;
	import sbt_pkg::*;

	localparam int DEPTH      = TABLE_DEPTH_DEF;
	localparam int POOL_SIZE  = 96;
	localparam int RANDOM_OPS = 1730;
	localparam int DRAIN_WAIT = 300;
	localparam int MAX_REPORT = 60;

	typedef struct {
		req_word_t word;
		bit        typed;
		rsp_word_t want;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	// Shadow of the table contents, kept in ascending order
	logic [ADDRESS_W-1:0] shadow_breakpoints[$];
	rsp_word_t            due_answers[$];
	stim_row_t            directed_rows[$];
	logic [ADDRESS_W-1:0] addr_pool[POOL_SIZE];

	// Answer typed into the table for the word on the bus, if any
	bit        cur_typed;
	rsp_word_t cur_want;
	int        burst_left;
	int        fail_count;

	sorted_breakpoint_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one command to the shadow set and return the answer it gives
	function automatic rsp_word_t apply_breakpoint_cmd(req_word_t w);
		int        lb;
		bit        hit;
		bit        want_ins;
		bit        want_del;
		status_e   st;
		rsp_word_t r;
		lb = 0;
		while (lb < shadow_breakpoints.size() && shadow_breakpoints[lb] < w.address)
			lb++;
		hit = (lb < shadow_breakpoints.size()) && (shadow_breakpoints[lb] == w.address);
		want_ins = !hit && w.enabled &&
			(w.command == CMD_CREATE || w.command == CMD_MODIFY);
		want_del = hit && (w.command == CMD_DELETE ||
			(w.command == CMD_MODIFY && !w.enabled));
		st = ST_NOCHANGE;
		if (want_ins) begin
			if (shadow_breakpoints.size() >= DEPTH) begin
				st = ST_FULL;
			end else begin
				shadow_breakpoints.insert(lb, w.address);
				st = ST_INSERTED;
			end
		end else if (want_del) begin
			shadow_breakpoints.delete(lb);
			st = ST_REMOVED;
		end
		if (st == ST_INSERTED)
			r.present = 1'b1;
		else if (st == ST_REMOVED || st == ST_FULL)
			r.present = 1'b0;
		else
			r.present = hit;
		r.position    = r.present ? POSITION_W'(lb) : '0;
		r.entry_count = COUNT_W'(shadow_breakpoints.size());
		r.status      = st;
		return r;
	endfunction

	task automatic add_row(input cmd_e c, input logic [ADDRESS_W-1:0] a, input logic e,
			input bit typed, input logic p, input logic [POSITION_W-1:0] pos,
			input logic [COUNT_W-1:0] cnt, input status_e st);
		stim_row_t row;
		row.word.command     = c;
		row.word.address     = a;
		row.word.enabled     = e;
		row.typed            = typed;
		row.want.present     = p;
		row.want.position    = pos;
		row.want.entry_count = cnt;
		row.want.status      = st;
		directed_rows.push_back(row);
	endtask

	task automatic report_mismatch(input string fld, input int unsigned exp_v,
			input int unsigned act_v);
		fail_count++;
		if (fail_count <= MAX_REPORT)
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, fld, exp_v, act_v);
	endtask

	// Offer one word, with burst gaps, and hold it until accepted (called at a falling edge)
	task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
		end
		burst_left--;
		req       = w;
		cur_typed = typed;
		cur_want  = want;
		req_valid = 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	// Check answers against the oldest expectation, then log newly accepted words
	always @(posedge clk) begin
		rsp_word_t exp_r;
		rsp_word_t pred_r;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (due_answers.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected word: expected none, actual %h", $time, rsp);
				end else begin
					exp_r = due_answers.pop_front();
					if (rsp.present !== exp_r.present)
						report_mismatch("present", 32'(exp_r.present), 32'(rsp.present));
					if (rsp.position !== exp_r.position)
						report_mismatch("position", 32'(exp_r.position), 32'(rsp.position));
					if (rsp.entry_count !== exp_r.entry_count)
						report_mismatch("entry_count", 32'(exp_r.entry_count),
							32'(rsp.entry_count));
					if (rsp.status !== exp_r.status)
						report_mismatch("status", 32'(exp_r.status), 32'(rsp.status));
				end
			end
			if (req_valid && !req_stall) begin
				pred_r = apply_breakpoint_cmd(req);
				due_answers.push_back(cur_typed ? cur_want : pred_r);
			end
		end
	end

	// Receiver: free, light and heavy stall stretches, with two long hold-offs
	initial begin
		int seg;
		int len;
		int mode;
		int k;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		for (seg = 0; ; seg++) begin
			if (seg == 3 || seg == 60) begin
				@(negedge clk);
				rsp_stall = 1'b1;
				for (k = 0; k < 500; k++)
					@(negedge clk);
				rsp_stall = 1'b0;
			end else begin
				mode = $urandom_range(0, 2);
				len  = $urandom_range(10, 150);
				for (k = 0; k < len; k++) begin
					@(negedge clk);
					case (mode)
						0: rsp_stall = 1'b0;
						1: rsp_stall = ($urandom_range(0, 3) == 0);
						default: rsp_stall = ($urandom_range(0, 3) != 0);
					endcase
				end
			end
		end
	end

	// Give up on a hung run
	initial begin
		#25_000_000;
		$display("[sorted_breakpoint_table_top] ERROR");
		$finish;
	end

	// Stimulus: directed table, then random phases that fill, mix and drain the table
	initial begin
		int        i;
		int        sent;
		int        phase;
		int        len;
		int        ins_pct;
		int        del_pct;
		int        r;
		req_word_t w;
		rsp_word_t none;

		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		cur_typed  = 1'b0;
		cur_want   = '0;
		burst_left = 0;
		fail_count = 0;
		none       = '0;

		// Build an address pool with the extremes and some adjacent pairs
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = (i % 4 == 0) ? addr_pool[i - 1] + 1 : ADDRESS_W'($urandom);

		add_row(CMD_FIND,   32'h0000_0000, 1'b0, 1'b1, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_DELETE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_CREATE, 32'h0000_0005, 1'b0, 1'b1, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_MODIFY, 32'h0000_0007, 1'b0, 1'b1, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_CREATE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 6'd0, 7'd1, ST_INSERTED);
		add_row(CMD_CREATE, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 6'd0, 7'd2, ST_INSERTED);
		add_row(CMD_CREATE, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 6'd0, 7'd2, ST_NOCHANGE);
		add_row(CMD_FIND,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 6'd1, 7'd2, ST_NOCHANGE);
		add_row(CMD_CREATE, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_MODIFY, 32'h1234_5678, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_MODIFY, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_MODIFY, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_CREATE, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_DELETE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_DELETE, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_FIND,   32'h1234_5678, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_FIND,   32'h5555_5555, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_DELETE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);
		add_row(CMD_DELETE, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, ST_NOCHANGE);

		// Hold reset, then release it once
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table
		foreach (directed_rows[j])
			send_word(directed_rows[j].word, directed_rows[j].typed, directed_rows[j].want);

		// Random phases: fill toward capacity, mix, drain toward empty
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_OPS) begin
			case (phase % 3)
				0: begin ins_pct = 70; del_pct = 12; len = $urandom_range(100, 220); end
				1: begin ins_pct = 40; del_pct = 40; len = $urandom_range(40, 160); end
				default: begin ins_pct = 12; del_pct = 70; len = $urandom_range(100, 220); end
			endcase
			for (i = 0; i < len && sent < RANDOM_OPS; i++) begin
				r = $urandom_range(0, 99);
				w.address = ($urandom_range(0, 9) == 0) ? ADDRESS_W'($urandom)
					: addr_pool[$urandom_range(0, POOL_SIZE - 1)];
				w.enabled = 1'($urandom_range(0, 1));
				if (r < ins_pct) begin
					w.command = ($urandom_range(0, 1) == 0) ? CMD_CREATE : CMD_MODIFY;
					w.enabled = ($urandom_range(0, 9) != 0);
				end else if (r < ins_pct + del_pct) begin
					if ($urandom_range(0, 1) == 0) begin
						w.command = CMD_DELETE;
					end else begin
						w.command = CMD_MODIFY;
						w.enabled = ($urandom_range(0, 9) == 0);
					end
				end else begin
					w.command = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3))
						: CMD_FIND;
				end
				send_word(w, 1'b0, none);
				sent++;
			end
			phase++;
		end
		req_valid = 1'b0;

		// Wait for every answer, then for stray words
		while (due_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("[sorted_breakpoint_table_top] OK");
		else
			$display("[sorted_breakpoint_table_top] ERROR");
		$finish;
	end

endmodule
